FILE: rtl/line_pixel_generator_defines.svh
// Assertion macros for the line pixel generator.
// Used by line_pixel_generator.sv; needs clk_i and rst_ni in scope.
`ifndef LINE_PIXEL_GENERATOR_DEFINES_SVH
`define LINE_PIXEL_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define LPG_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define LPG_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`define LPG_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define LPG_ASSERT(name, prop, msg)
`define LPG_ASSERT_NEXT(name, ante, cons, msg)
`define LPG_ASSERT_NEVER(name, cond, msg)
`endif

`endif

FILE: rtl/lpg_pkg.sv
// Shared constants and types for the line pixel generator.
// No dependencies.
package lpg_pkg;

  localparam int COORD_BITS = 10;
  localparam int ERR_BITS   = COORD_BITS + 3;
  localparam int STRT_BITS  = COORD_BITS + 2;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [COORD_BITS-1:0]      cur_x;
    logic [COORD_BITS-1:0]      cur_y;
    logic [COORD_BITS-1:0]      target_x;
    logic [COORD_BITS-1:0]      target_y;
    logic signed [ERR_BITS-1:0] error_term;
    logic signed [ERR_BITS-1:0] diag_inc;
    logic [STRT_BITS-1:0]       straight_inc;
    logic                       x_neg;
    logic                       y_neg;
    logic                       x_major;
    logic                       active;
  } line_state_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  last_pixel;
    logic                  pixel_valid;
  } pixel_t;

endpackage

FILE: rtl/lpg_setup.sv
// Line setup: directions, major axis, increments and error term from endpoints.
// Depends on lpg_pkg.
module lpg_setup (
  input  logic [lpg_pkg::COORD_BITS-1:0] start_x_i,
  input  logic [lpg_pkg::COORD_BITS-1:0] start_y_i,
  input  logic [lpg_pkg::COORD_BITS-1:0] end_x_i,
  input  logic [lpg_pkg::COORD_BITS-1:0] end_y_i,
  output lpg_pkg::line_state_t           state_o,
  output logic                           last_o
);
  import lpg_pkg::*;

  logic                       x_neg, y_neg, x_major;
  logic [COORD_BITS-1:0]      dx, dy, major, minor;
  logic signed [ERR_BITS-1:0] maj_s, min_s;
  logic [STRT_BITS-1:0]       straight;

  always_comb begin
    x_neg   = !(start_x_i < end_x_i);
    y_neg   = !(start_y_i < end_y_i);
    dx      = x_neg ? start_x_i - end_x_i : end_x_i - start_x_i;
    dy      = y_neg ? start_y_i - end_y_i : end_y_i - start_y_i;
    x_major = dx > dy;
    major   = x_major ? dx : dy;
    minor   = x_major ? dy : dx;
    maj_s   = signed'({{(ERR_BITS-COORD_BITS){1'b0}}, major});
    min_s   = signed'({{(ERR_BITS-COORD_BITS){1'b0}}, minor});
    straight = {{(STRT_BITS-COORD_BITS-1){1'b0}}, minor, 1'b0};

    last_o = x_major ? (start_x_i == end_x_i) : (start_y_i == end_y_i);

    state_o.cur_x        = start_x_i;
    state_o.cur_y        = start_y_i;
    state_o.target_x     = end_x_i;
    state_o.target_y     = end_y_i;
    state_o.diag_inc     = (min_s - maj_s) <<< 1;
    state_o.straight_inc = straight;
    state_o.error_term   = signed'({{(ERR_BITS-STRT_BITS){1'b0}}, straight}) - maj_s;
    state_o.x_neg        = x_neg;
    state_o.y_neg        = y_neg;
    state_o.x_major      = x_major;
    state_o.active       = !last_o;
  end

endmodule

FILE: rtl/lpg_step.sv
// One Bresenham step: moves the current pixel and updates the error term.
// Depends on lpg_pkg.
module lpg_step (
  input  lpg_pkg::line_state_t state_i,
  output lpg_pkg::line_state_t state_o,
  output logic                 last_o
);
  import lpg_pkg::*;

  logic                  diag;
  logic                  move_x, move_y;
  logic [COORD_BITS-1:0] nx, ny;

  always_comb begin
    diag   = !state_i.error_term[ERR_BITS-1];
    move_x = diag || state_i.x_major;
    move_y = diag || !state_i.x_major;
    nx = state_i.cur_x;
    ny = state_i.cur_y;
    if (move_x) begin
      nx = state_i.x_neg ? state_i.cur_x - 1'b1 : state_i.cur_x + 1'b1;
    end
    if (move_y) begin
      ny = state_i.y_neg ? state_i.cur_y - 1'b1 : state_i.cur_y + 1'b1;
    end
    last_o = state_i.x_major ? (nx == state_i.target_x) : (ny == state_i.target_y);

    state_o       = state_i;
    state_o.cur_x = nx;
    state_o.cur_y = ny;
    if (diag) begin
      state_o.error_term = state_i.error_term + state_i.diag_inc;
    end else begin
      state_o.error_term = state_i.error_term
                         + signed'({{(ERR_BITS-STRT_BITS){1'b0}}, state_i.straight_inc});
    end
    state_o.active = !last_o;
  end

endmodule

FILE: rtl/lpg_out_buf.sv
// Two-entry output buffer (output register plus skid register).
// Depends on lpg_pkg.
module lpg_out_buf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  lpg_pkg::pixel_t in_data_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  output lpg_pkg::pixel_t out_data_o,
  input  logic            out_stall_i
);
  import lpg_pkg::*;

  logic   out_valid_q, skid_valid_q;
  logic   out_valid_d, skid_valid_d;
  pixel_t out_q, skid_q, out_d, skid_d;
  logic   in_acc, out_free;

  assign in_acc   = in_valid_i && !skid_valid_q;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = in_data_i;
        out_valid_d = in_acc;
      end
    end else if (in_acc) begin
      skid_d       = in_data_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/line_pixel_generator.sv
// Bresenham line rasterizer, all octants. An accepted request's pixel is registered in the
// output register, or in the skid register if the output stalls. Throughput: one request per
// cycle while not stalled; the line state register is updated in the same cycle the request is taken.
// A two-entry output buffer keeps requests flowing while one result waits.
// Reset (async, active low) clears the line state (no line active) and the buffer.
// Depends on lpg_pkg, lpg_setup, lpg_step, lpg_out_buf and the defines header.
`include "line_pixel_generator_defines.svh"

module line_pixel_generator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           command_i,
  input  logic [lpg_pkg::COORD_BITS-1:0] start_x_i,
  input  logic [lpg_pkg::COORD_BITS-1:0] start_y_i,
  input  logic [lpg_pkg::COORD_BITS-1:0] end_x_i,
  input  logic [lpg_pkg::COORD_BITS-1:0] end_y_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [lpg_pkg::COORD_BITS-1:0] pixel_x_o,
  output logic [lpg_pkg::COORD_BITS-1:0] pixel_y_o,
  output logic                           last_pixel_o,
  output logic                           pixel_valid_o
);
  import lpg_pkg::*;

  line_state_t state_q, state_d, setup_state, step_state;
  logic        setup_last, step_last;
  logic        in_acc, is_step;
  pixel_t      result, out_data;

  lpg_setup u_setup (
    .start_x_i (start_x_i),
    .start_y_i (start_y_i),
    .end_x_i   (end_x_i),
    .end_y_i   (end_y_i),
    .state_o   (setup_state),
    .last_o    (setup_last)
  );

  lpg_step u_step (
    .state_i (state_q),
    .state_o (step_state),
    .last_o  (step_last)
  );

  assign in_acc  = in_valid_i && !in_stall_o;
  assign is_step = (command_i == CMD_STEP);

  always_comb begin
    state_d = state_q;
    result  = '0;
    if (!is_step) begin
      state_d            = setup_state;
      result.pixel_x     = setup_state.cur_x;
      result.pixel_y     = setup_state.cur_y;
      result.last_pixel  = setup_last;
      result.pixel_valid = 1'b1;
    end else if (state_q.active) begin
      state_d            = step_state;
      result.pixel_x     = step_state.cur_x;
      result.pixel_y     = step_state.cur_y;
      result.last_pixel  = step_last;
      result.pixel_valid = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_acc) begin
      state_q <= state_d;
    end
  end

  lpg_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (result),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data),
    .out_stall_i (out_stall_i)
  );

  assign pixel_x_o     = out_data.pixel_x;
  assign pixel_y_o     = out_data.pixel_y;
  assign last_pixel_o  = out_data.last_pixel;
  assign pixel_valid_o = out_data.pixel_valid;

  `LPG_ASSERT_NEXT(a_idle_step_keeps_state, in_acc && is_step && !state_q.active, $stable(state_q), "step with no line changed state")
  `LPG_ASSERT_NEXT(a_point_line_inactive, in_acc && !is_step && (start_x_i == end_x_i) && (start_y_i == end_y_i), !state_q.active, "one-point line left active")
  `LPG_ASSERT_NEVER(a_stall_needs_output, in_stall_o && !out_valid_o, "input stalled with empty output")
  `LPG_ASSERT(a_last_ends_line, (in_acc && result.last_pixel) |=> !state_q.active, "line still active after last pixel")

endmodule

FILE: tb/sv/line_pixel_generator_test.sv
// Self-checking testbench for line_pixel_generator: directed and random line requests,
// predicted pixel by pixel and compared with each result. Random gaps on both sides, except back-to-back.
// Depends on lpg_pkg and the line_pixel_generator RTL.
module line_pixel_generator_test;
  import lpg_pkg::*;

  typedef logic [COORD_BITS-1:0] coord_t;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   in_valid_i = 1'b0;
  logic   in_stall_o;
  logic   command_i = 1'b0;
  coord_t start_x_i = '0;
  coord_t start_y_i = '0;
  coord_t end_x_i = '0;
  coord_t end_y_i = '0;
  logic   out_valid_o;
  logic   out_stall_i = 1'b0;
  coord_t pixel_x_o;
  coord_t pixel_y_o;
  logic   last_pixel_o;
  logic   pixel_valid_o;

  line_pixel_generator uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .command_i,
    .start_x_i, .start_y_i, .end_x_i, .end_y_i,
    .out_valid_o, .out_stall_i, .pixel_x_o, .pixel_y_o, .last_pixel_o, .pixel_valid_o
  );

  // line tracker state
  coord_t                     cur_x = '0, cur_y = '0, tgt_x = '0, tgt_y = '0;
  logic signed [ERR_BITS-1:0] err = '0, diag_inc = '0;
  logic [STRT_BITS-1:0]       strt_inc = '0;
  logic                       x_neg = 1'b0, y_neg = 1'b0, x_major = 1'b0, active = 1'b0;

  pixel_t expected_pixels[$];
  int     mismatches = 0;
  int     sent = 0;
  bit     no_gaps = 1'b0;

  initial forever #5 clk_i = ~clk_i;

  initial begin
    #3_000_000;
    $display("FAIL line_pixel_generator");
    $finish;
  end

  function automatic coord_t nudge(coord_t c, logic neg);
    return neg ? c - 1'b1 : c + 1'b1;
  endfunction

  function automatic pixel_t rasterize(cmd_e cmd, coord_t sx, coord_t sy, coord_t ex,
                                       coord_t ey);
    pixel_t px;
    coord_t dx, dy, major, minor;
    logic   last;
    px = '0;
    if (cmd == CMD_START) begin
      x_neg = !(sx < ex);
      dx = x_neg ? sx - ex : ex - sx;
      y_neg = !(sy < ey);
      dy = y_neg ? sy - ey : ey - sy;
      x_major = dx > dy;
      major = x_major ? dx : dy;
      minor = x_major ? dy : dx;
      diag_inc = ($signed({3'b000, minor}) - $signed({3'b000, major})) <<< 1;
      strt_inc = {1'b0, minor, 1'b0};
      err = $signed({1'b0, strt_inc}) - $signed({3'b000, major});
      cur_x = sx;
      cur_y = sy;
      tgt_x = ex;
      tgt_y = ey;
    end else begin
      if (!active) return px;
      if (err >= 0) begin
        cur_x = nudge(cur_x, x_neg);
        cur_y = nudge(cur_y, y_neg);
        err = err + diag_inc;
      end else begin
        if (x_major) cur_x = nudge(cur_x, x_neg);
        else cur_y = nudge(cur_y, y_neg);
        err = err + $signed({1'b0, strt_inc});
      end
    end
    last = x_major ? (cur_x == tgt_x) : (cur_y == tgt_y);
    active = !last;
    px.pixel_x = cur_x;
    px.pixel_y = cur_y;
    px.last_pixel = last;
    px.pixel_valid = 1'b1;
    return px;
  endfunction

  task automatic send_req(cmd_e cmd, coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    while (!no_gaps && $urandom_range(99) < 34) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    start_x_i <= sx;
    start_y_i <= sy;
    end_x_i <= ex;
    end_y_i <= ey;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_pixels.push_back(rasterize(cmd, sx, sy, ex, ey));
    sent++;
  endtask

  task automatic step_req();
    send_req(CMD_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
             coord_t'($urandom));
  endtask

  // start a line, step until it ends or max_steps, then extra steps past that
  task automatic trace_line(coord_t sx, coord_t sy, coord_t ex, coord_t ey, int max_steps,
                            int extra);
    int n;
    send_req(CMD_START, sx, sy, ex, ey);
    n = 0;
    while (active && n < max_steps) begin
      step_req();
      n++;
    end
    repeat (extra) step_req();
  endtask

  function automatic coord_t near(coord_t c, int span);
    int v;
    v = int'(c) + int'($urandom_range(2 * span)) - span;
    if (v < 0) v = 0;
    if (v > (1 << COORD_BITS) - 1) v = (1 << COORD_BITS) - 1;
    return coord_t'(v);
  endfunction

  task automatic test_idle_steps();
    repeat (3) step_req();
  endtask

  task automatic test_directed_lines();
    trace_line(512, 300, 512, 300, 0, 1);
    trace_line('0, '1, '1, '0, 3, 0);
    trace_line('1, '1, 1020, '1, 8, 1);
    trace_line(0, 0, 0, 2, 8, 0);
    trace_line(5, 5, 8, 8, 8, 1);
    trace_line(20, 10, 16, 12, 8, 0);
  endtask

  task automatic test_random_lines(int target);
    int     r, span;
    coord_t sx, sy;
    while (sent < target) begin
      r = $urandom_range(99);
      sx = coord_t'($urandom);
      sy = coord_t'($urandom);
      if (r < 80) begin
        span = ($urandom_range(3) == 0) ? 40 : 12;
        trace_line(sx, sy, near(sx, span), near(sy, span),
                   ($urandom_range(9) == 0) ? $urandom_range(4) : 4096,
                   ($urandom_range(3) == 0) ? $urandom_range(2) + 1 : 0);
      end else if (r == 80) begin
        trace_line(sx, sy, coord_t'($urandom), coord_t'($urandom), 4096, 1);
      end else if (r < 86) begin
        trace_line(sx, sy, coord_t'($urandom), coord_t'($urandom), $urandom_range(20), 0);
      end else begin
        send_req(cmd_e'($urandom_range(1)), sx, sy, coord_t'($urandom), coord_t'($urandom));
      end
    end
  endtask

  task automatic test_back_to_back(int target);
    no_gaps = 1'b1;
    test_random_lines(target);
    no_gaps = 1'b0;
  endtask

  always @(posedge clk_i) out_stall_i <= !no_gaps && ($urandom_range(99) < 34);

  always @(posedge clk_i) begin
    pixel_t want, got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.pixel_x = pixel_x_o;
      got.pixel_y = pixel_y_o;
      got.last_pixel = last_pixel_o;
      got.pixel_valid = pixel_valid_o;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected pixel x=%0d y=%0d last=%b valid=%b", got.pixel_x,
                   got.pixel_y, got.last_pixel, got.pixel_valid);
      end else begin
        want = expected_pixels.pop_front();
        if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
            got.last_pixel !== want.last_pixel || got.pixel_valid !== want.pixel_valid) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pixel mismatch: exp x=%0d y=%0d last=%b valid=%b, got x=%0d y=%0d last=%b valid=%b",
                     want.pixel_x, want.pixel_y, want.last_pixel, want.pixel_valid,
                     got.pixel_x, got.pixel_y, got.last_pixel, got.pixel_valid);
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_steps();
    test_directed_lines();
    test_random_lines(900);
    test_back_to_back(1200);
    test_random_lines(1900);
    in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("PASS line_pixel_generator");
    end else begin
      $display("FAIL line_pixel_generator");
    end
    $finish;
  end

endmodule
